@@ rtl/skcmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Shortcut key match table package
// Shared types, codes and the modifier match function of the shortcut table.
// ----------------------------------------------------------------------------
package skcmt_pkg;

	// Default number of table entries.
	localparam int TABLE_DEPTH_DEF = 16;

	// Widths of the request and result fields.
	localparam int KEY_W   = 9;
	localparam int KIND_W  = 3;
	localparam int MODS_W  = 6;
	localparam int WIN_W   = 16;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 3;

	typedef enum logic [1:0] {
		OP_ADD       = 2'd0,
		OP_DELETE    = 2'd1,
		OP_TRANSLATE = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EXISTS  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOMATCH = 3'd3;
	localparam logic [STAT_W-1:0] STAT_OWNER   = 3'd4;

	// Message kinds of a translate request.
	localparam logic [KIND_W-1:0] KIND_KEYDOWN    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SYSKEYDOWN = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CHAR       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SYSCHAR    = 3'd3;

	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [KIND_W-1:0]  kind;
		logic [MODS_W-1:0]  mods;
		logic [WIN_W-1:0]   win;
		logic [WORD_W-1:0]  word;
		logic [WORD_W-1:0]  param;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               notify_valid;
		logic               notify_system;
		logic [WORD_W-1:0]  notify_word;
		logic [WORD_W-1:0]  notify_param;
	} res_t;

	// One stored table entry.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [MODS_W-1:0]  mods;
		logic [WORD_W-1:0]  word;
		logic [WORD_W-1:0]  param;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	// A group with both sides stored accepts either side; otherwise the pair must be equal.
	function automatic logic group_ok(input logic [1:0] stored, input logic [1:0] asked);
		if (stored == 2'b11) begin
			return |asked;
		end
		return stored == asked;
	endfunction

	function automatic logic mods_match(input logic [MODS_W-1:0] stored,
			input logic [MODS_W-1:0] asked);
		return group_ok(stored[1:0], asked[1:0]) && group_ok(stored[3:2], asked[3:2])
			&& group_ok(stored[5:4], asked[5:4]);
	endfunction

endpackage

@@ rtl/skcmt_req_if.sv @@
// ----------------------------------------------------------------------------
// Shortcut table request channel
// Valid/ready channel that carries one table request.
// ----------------------------------------------------------------------------
interface skcmt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [8:0]  key;
	logic [2:0]  message_kind;
	logic [5:0]  modifiers;
	logic [15:0] window_id;
	logic [31:0] command_word;
	logic [31:0] command_param;

	modport source (
		output valid, operation, key, message_kind, modifiers, window_id,
			command_word, command_param,
		input  ready
	);
	modport sink (
		input  valid, operation, key, message_kind, modifiers, window_id,
			command_word, command_param,
		output ready
	);
endinterface

@@ rtl/skcmt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Shortcut table response channel
// Valid/ready channel that carries one request result.
// ----------------------------------------------------------------------------
interface skcmt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        notify_valid;
	logic        notify_system;
	logic [31:0] notify_word;
	logic [31:0] notify_param;

	modport source (
		output valid, status, notify_valid, notify_system, notify_word, notify_param,
		input  ready
	);
	modport sink (
		input  valid, status, notify_valid, notify_system, notify_word, notify_param,
		output ready
	);
endinterface

@@ rtl/skcmt_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Shortcut table configuration channel
// Valid/ready write channel for the owner window register.
// ----------------------------------------------------------------------------
interface skcmt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

@@ rtl/skcmt_mem.sv @@
// ----------------------------------------------------------------------------
// Shortcut table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skcmt_mem #(
	parameter int DEPTH = skcmt_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  skcmt_pkg::entry_t    wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output skcmt_pkg::entry_t    rd_data
);

	skcmt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/skcmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Shortcut table controller
// Walks the entry memory for lookups, appends entries and compacts on delete.
// ----------------------------------------------------------------------------
module skcmt_ctrl #(
	parameter int DEPTH = skcmt_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  skcmt_pkg::req_t      req,
	input  logic [15:0]          owner_window,
	input  logic                 out_free,
	output logic                 res_valid,
	output skcmt_pkg::res_t      res,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output skcmt_pkg::entry_t    wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  skcmt_pkg::entry_t    rd_data
);

	// Entries sit oldest first at addresses 0 .. count-1; lookups walk downward
	// from the newest one.
	skcmt_pkg::state_t state_q, state_d;
	logic [CW-1:0]         count_q;
	skcmt_pkg::req_t       cur_q;
	logic [skcmt_pkg::KEY_W-1:0] key_q;
	logic [AW-1:0]         ptr_q;
	logic [CW-1:0]         left_q;
	logic                  inflight_s1;
	logic [AW-1:0]         addr_s1;
	logic [AW-1:0]         dest_q;
	skcmt_pkg::res_t       res_q;

	logic accept, early, hit, miss, full, shift_last;
	logic [CW-1:0] count_m1;

	assign accept   = req_valid && req_ready;
	assign early    = (req.op == skcmt_pkg::OP_CLEAR)
		|| ((req.op == skcmt_pkg::OP_TRANSLATE)
			&& ((req.win != owner_window) || (req.kind > skcmt_pkg::KIND_SYSCHAR)));
	assign hit      = inflight_s1 && (rd_data.key == key_q)
		&& skcmt_pkg::mods_match(rd_data.mods, cur_q.mods);
	assign miss     = !inflight_s1 && (left_q == '0);
	assign full     = count_q == CW'(DEPTH);
	assign count_m1 = count_q - CW'(1);
	assign shift_last = CW'(dest_q) == count_m1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skcmt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = early ? skcmt_pkg::S_RESP : skcmt_pkg::S_SCAN;
				end
			end
			skcmt_pkg::S_SCAN: begin
				if (hit) begin
					state_d = (cur_q.op == skcmt_pkg::OP_DELETE) ? skcmt_pkg::S_SHIFT_RD
						: skcmt_pkg::S_RESP;
				end else if (miss) begin
					state_d = skcmt_pkg::S_RESP;
				end
			end
			skcmt_pkg::S_SHIFT_RD: begin
				state_d = shift_last ? skcmt_pkg::S_RESP : skcmt_pkg::S_SHIFT_WR;
			end
			skcmt_pkg::S_SHIFT_WR: begin
				state_d = skcmt_pkg::S_SHIFT_RD;
			end
			skcmt_pkg::S_RESP: begin
				if (out_free) begin
					state_d = skcmt_pkg::S_IDLE;
				end
			end
			default: state_d = skcmt_pkg::S_IDLE;
		endcase
	end

	// Outputs and memory port controls.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = ptr_q;
		wr_en     = 1'b0;
		wr_addr   = dest_q;
		wr_data   = rd_data;
		unique case (state_q)
			skcmt_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			skcmt_pkg::S_SCAN: begin
				if (!hit && !miss && (left_q != '0)) begin
					rd_en = 1'b1;
				end
				if (miss && (cur_q.op == skcmt_pkg::OP_ADD) && !full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = '{key: cur_q.key, mods: cur_q.mods, word: cur_q.word,
						param: cur_q.param};
				end
			end
			skcmt_pkg::S_SHIFT_RD: begin
				if (!shift_last) begin
					rd_en   = 1'b1;
					rd_addr = dest_q + AW'(1);
				end
			end
			skcmt_pkg::S_SHIFT_WR: begin
				wr_en = 1'b1;
			end
			skcmt_pkg::S_RESP: begin
				res_valid = out_free;
			end
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skcmt_pkg::S_IDLE;
			count_q     <= '0;
			inflight_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			inflight_s1 <= rd_en && (state_q == skcmt_pkg::S_SCAN);
			if (accept && (req.op == skcmt_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en && (state_q == skcmt_pkg::S_SCAN)) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == skcmt_pkg::S_SHIFT_RD) && shift_last) begin
				count_q <= count_m1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= req;
			ptr_q  <= count_m1[AW-1:0];
			left_q <= count_q;
			if (req.op == skcmt_pkg::OP_TRANSLATE) begin
				key_q <= {(req.kind == skcmt_pkg::KIND_KEYDOWN)
					|| (req.kind == skcmt_pkg::KIND_SYSKEYDOWN), req.key[7:0]};
			end else begin
				key_q <= req.key;
			end
			res_q <= '{
				status: (req.op != skcmt_pkg::OP_TRANSLATE) ? skcmt_pkg::STAT_OK
					: ((req.win != owner_window) ? skcmt_pkg::STAT_OWNER
					: skcmt_pkg::STAT_NOMATCH),
				notify_valid: 1'b0,
				notify_system: 1'b0,
				notify_word: '0,
				notify_param: '0
			};
		end
		if (rd_en && (state_q == skcmt_pkg::S_SCAN)) begin
			ptr_q   <= ptr_q - AW'(1);
			left_q  <= left_q - CW'(1);
			addr_s1 <= ptr_q;
		end
		if (state_q == skcmt_pkg::S_SCAN) begin
			if (hit) begin
				dest_q <= addr_s1;
				unique case (cur_q.op)
					skcmt_pkg::OP_ADD: res_q.status <= skcmt_pkg::STAT_EXISTS;
					skcmt_pkg::OP_TRANSLATE: begin
						res_q.status        <= skcmt_pkg::STAT_OK;
						res_q.notify_valid  <= 1'b1;
						res_q.notify_system <= (cur_q.kind == skcmt_pkg::KIND_SYSKEYDOWN)
							|| (cur_q.kind == skcmt_pkg::KIND_SYSCHAR);
						res_q.notify_word   <= rd_data.word;
						res_q.notify_param  <= rd_data.param;
					end
					default: res_q.status <= skcmt_pkg::STAT_OK;
				endcase
			end else if (miss) begin
				if (cur_q.op == skcmt_pkg::OP_ADD) begin
					res_q.status <= full ? skcmt_pkg::STAT_FULL : skcmt_pkg::STAT_OK;
				end else begin
					res_q.status <= skcmt_pkg::STAT_NOMATCH;
				end
			end
		end
		if (state_q == skcmt_pkg::S_SHIFT_WR) begin
			dest_q <= dest_q + AW'(1);
		end
	end

endmodule

@@ rtl/shortcut_key_match_table_top.sv @@
// ----------------------------------------------------------------------------
// Shortcut key match table
// Keyboard shortcut table with add, delete, clear and translate requests.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel and each one produces exactly one
// transaction on the rsp channel. The cfg channel writes the owner window; it
// is always ready and should only be written while no request is in flight.
// Timing: clear, and a translate refused for its owner or message kind, go
// straight to the response state once accepted. Add, delete and accepted
// translates walk the entry memory from the newest entry down, one read per
// cycle through the single read port, until a match or the oldest entry is
// read. A delete then compacts the entries newer than the removed one, each
// by a read and then a write back into the slot just below it.
// One request is worked at a time; the next is accepted once the previous
// result sits in the output register, even if the receiver has not taken it.
// Reset empties the table (the fill count goes to zero) and clears the owner
// window; no clearing pass is needed. When the receiver stalls, the finished
// result waits in the controller until the output register frees up.
// ----------------------------------------------------------------------------
module shortcut_key_match_table_top #(
	parameter int TABLE_DEPTH = skcmt_pkg::TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	skcmt_req_if.sink    req,
	skcmt_rsp_if.source  rsp,
	skcmt_cfg_if.sink    cfg
);

	// Address and fill count widths follow the table depth.
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [15:0]        owner_q;
	logic               out_valid_q;
	skcmt_pkg::res_t    out_q;
	skcmt_pkg::req_t    req_bus;
	skcmt_pkg::res_t    res;
	skcmt_pkg::entry_t  wr_data, rd_data;
	logic               res_valid, out_free, req_ready;
	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;

	// The owner register takes every write at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
		end else if (cfg.valid) begin
			owner_q <= cfg.data;
		end
	end

	assign req_bus = '{op: skcmt_pkg::op_t'(req.operation), key: req.key,
		kind: req.message_kind, mods: req.modifiers, win: req.window_id,
		word: req.command_word, param: req.command_param};
	assign req.ready = req_ready;

	skcmt_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	skcmt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_ready    (req_ready),
		.req          (req_bus),
		.owner_window (owner_q),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	// Output register: free when empty or being drained this cycle.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.notify_valid  = out_q.notify_valid;
	assign rsp.notify_system = out_q.notify_system;
	assign rsp.notify_word   = out_q.notify_word;
	assign rsp.notify_param  = out_q.notify_param;

endmodule
